// File: rtl/wavhp_pkg.sv
// Shared types and constants for the WAV header parser.
package wavhp_pkg;

    // Container and chunk tags, assembled little-endian.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Format limits and defaults.
    localparam logic [31:0] DEFAULT_RATE     = 32'd44100;
    localparam logic [15:0] DEFAULT_CHANNELS = 16'd2;
    localparam logic [15:0] PCM_FORMAT       = 16'd1;
    localparam logic [15:0] PCM_DEPTH        = 16'd16;
    localparam logic [31:0] FMT_BODY_BYTES   = 32'd16;
    localparam logic [31:0] POS_MAX          = 32'hFFFF_FFFF;

    // Field byte counts at which a word completes.
    localparam logic [3:0] IDX_ZERO = 4'd0;
    localparam logic [3:0] IDX_HALF = 4'd2;
    localparam logic [3:0] IDX_WORD = 4'd4;
    localparam logic [3:0] IDX_RATE = 4'd8;

    // Result status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_TAG     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_INCOMPLETE  = 2'd3;

    // Stream widths.
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 120;
    localparam int OUT_USER_W = 2;

    // Parse phase, one-hot.
    typedef enum logic [6:0] {
        PH_RIFF = 7'b000_0001,
        PH_SIZE = 7'b000_0010,
        PH_WAVE = 7'b000_0100,
        PH_ID   = 7'b000_1000,
        PH_LEN  = 7'b001_0000,
        PH_BODY = 7'b010_0000,
        PH_SKIP = 7'b100_0000
    } phase_t;

    // One input byte with its frame marks.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_of_file;
        logic       last_of_file;
    } in_item_t;

    // One parse result.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] payload_offset;
        logic [31:0] data_length;
        logic [31:0] fmt_rate;
        logic [15:0] channel_count;
        logic        rate_differs;
    } result_t;

    // Handshake between the parse core and the stages around it.
    typedef struct packed {
        logic step;
        logic load;
    } core_ctl_t;

endpackage

// File: rtl/wavhp_in_reg.sv
// Input register stage holding one byte transaction ahead of the parse core.
module wavhp_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    input  wavhp_pkg::in_item_t s_item,
    output logic                item_valid,
    output wavhp_pkg::in_item_t item,
    input  logic                take
);
    import wavhp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The stage frees up when the core consumes the held byte.
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/wavhp_parse_core.sv
// Parse state registers and the one-byte state update of the RIFF/WAVE walker.
module wavhp_parse_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  wavhp_pkg::in_item_t  item,
    input  logic                 out_free,
    input  logic [31:0]          nominal_rate,
    output wavhp_pkg::core_ctl_t ctl,
    output wavhp_pkg::result_t   result
);
    import wavhp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] asm_reg, asm_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] skip_reg, skip_next;
    logic [15:0] fcode_reg, fcode_next;
    logic [15:0] depth_reg, depth_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] chan_reg, chan_next;
    logic        found_reg, found_next;
    logic        concl_reg, concl_next;

    // State as seen after an optional restart.
    phase_t      phase_cur;
    logic [3:0]  idx_cur;
    logic [31:0] pos_cur, asm_cur, tag_cur, len_cur, skip_cur;
    logic [15:0] fcode_cur;
    logic        found_cur, concl_cur;

    logic        first;
    logic [3:0]  n;
    logic [31:0] skip_dec;
    logic        done;
    logic [1:0]  status;
    logic [31:0] offset;
    logic [31:0] length;

    assign first     = item.first_of_file;
    assign phase_cur = first ? PH_RIFF : phase_reg;
    assign idx_cur   = first ? IDX_ZERO : idx_reg;
    assign pos_cur   = first ? '0 : pos_reg;
    assign asm_cur   = first ? '0 : asm_reg;
    assign tag_cur   = first ? '0 : tag_reg;
    assign len_cur   = first ? '0 : len_reg;
    assign skip_cur  = first ? '0 : skip_reg;
    assign fcode_cur = first ? '0 : fcode_reg;
    assign found_cur = first ? 1'b0 : found_reg;
    assign concl_cur = first ? 1'b0 : concl_reg;
    assign n         = idx_cur + 4'd1;
    assign skip_dec  = (skip_cur != '0) ? skip_cur - 32'd1 : '0;

    // One byte of parse work.
    always_comb
    begin
        phase_next = phase_cur;
        idx_next   = idx_cur;
        pos_next   = pos_cur;
        asm_next   = asm_cur;
        tag_next   = tag_cur;
        len_next   = len_cur;
        skip_next  = skip_cur;
        fcode_next = fcode_cur;
        depth_next = first ? '0 : depth_reg;
        rate_next  = rate_reg;
        chan_next  = chan_reg;
        found_next = found_cur;
        concl_next = concl_cur;
        done       = 1'b0;
        status     = ST_OK;
        offset     = '0;
        length     = '0;
        if (!concl_cur)
        begin
            pos_next = (pos_cur != POS_MAX) ? pos_cur + 32'd1 : pos_cur;
            asm_next = {item.byte_value, asm_cur[31:8]};
            idx_next = n;
            case (phase_cur)
                PH_RIFF, PH_WAVE:
                begin
                    if (n == IDX_WORD)
                    begin
                        idx_next = IDX_ZERO;
                        if (asm_next != ((phase_cur == PH_RIFF) ? TAG_RIFF : TAG_WAVE))
                        begin
                            done   = 1'b1;
                            status = ST_BAD_TAG;
                        end
                        else
                        begin
                            phase_next = (phase_cur == PH_RIFF) ? PH_SIZE : PH_ID;
                        end
                    end
                end
                PH_SIZE:
                begin
                    if (n == IDX_WORD)
                    begin
                        idx_next   = IDX_ZERO;
                        phase_next = PH_WAVE;
                    end
                end
                PH_ID:
                begin
                    if (n == IDX_WORD)
                    begin
                        idx_next   = IDX_ZERO;
                        tag_next   = asm_next;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (n == IDX_WORD)
                    begin
                        idx_next = IDX_ZERO;
                        len_next = asm_next;
                        if (tag_cur == TAG_DATA)
                        begin
                            done   = 1'b1;
                            status = found_cur ? ST_OK : ST_INCOMPLETE;
                            offset = pos_next;
                            length = asm_next;
                        end
                        else if (tag_cur == TAG_FMT)
                        begin
                            phase_next = PH_BODY;
                        end
                        else
                        begin
                            skip_next  = asm_next;
                            phase_next = (asm_next != '0) ? PH_SKIP : PH_ID;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (n == IDX_HALF)
                    begin
                        fcode_next = asm_next[31:16];
                    end
                    else if (n == IDX_WORD)
                    begin
                        chan_next = asm_next[31:16];
                    end
                    else if (n == IDX_RATE)
                    begin
                        rate_next = asm_next;
                    end
                    else if (n == IDX_ZERO)
                    begin
                        // Sixteenth field byte: the counter has wrapped.
                        depth_next = asm_next[31:16];
                        if (fcode_cur != PCM_FORMAT || asm_next[31:16] != PCM_DEPTH)
                        begin
                            done   = 1'b1;
                            status = ST_UNSUPPORTED;
                        end
                        else
                        begin
                            found_next = 1'b1;
                            skip_next  = (len_cur > FMT_BODY_BYTES) ?
                                         len_cur - FMT_BODY_BYTES : '0;
                            phase_next = (len_cur > FMT_BODY_BYTES) ? PH_SKIP : PH_ID;
                        end
                    end
                end
                PH_SKIP:
                begin
                    idx_next  = IDX_ZERO;
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = PH_ID;
                    end
                end
                default:
                begin
                    idx_next   = IDX_ZERO;
                    phase_next = PH_ID;
                end
            endcase
            if (!done && item.last_of_file)
            begin
                done   = 1'b1;
                status = ST_INCOMPLETE;
            end
            if (done)
            begin
                concl_next = 1'b1;
            end
        end
    end

    // A byte is consumed unless its result would overwrite a waiting one.
    assign ctl.step = item_valid && (!done || out_free);
    assign ctl.load = ctl.step && done;

    assign result.status         = status;
    assign result.payload_offset = offset;
    assign result.data_length    = length;
    assign result.fmt_rate       = rate_next;
    assign result.channel_count  = chan_next;
    assign result.rate_differs   = (rate_next != nominal_rate);

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF;
            idx_reg   <= '0;
            pos_reg   <= '0;
            asm_reg   <= '0;
            tag_reg   <= '0;
            len_reg   <= '0;
            skip_reg  <= '0;
            fcode_reg <= '0;
            depth_reg <= '0;
            rate_reg  <= DEFAULT_RATE;
            chan_reg  <= DEFAULT_CHANNELS;
            found_reg <= 1'b0;
            concl_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            asm_reg   <= asm_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            skip_reg  <= skip_next;
            fcode_reg <= fcode_next;
            depth_reg <= depth_next;
            rate_reg  <= rate_next;
            chan_reg  <= chan_next;
            found_reg <= found_next;
            concl_reg <= concl_next;
        end
    end

endmodule

// File: rtl/wavhp_out_reg.sv
// Result register that holds one parse result until the downstream takes it.
module wavhp_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  wavhp_pkg::result_t result_in,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output wavhp_pkg::result_t result_out
);
    import wavhp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign m_valid    = valid_reg;
    assign result_out = result_reg;

endmodule

// File: rtl/wav_header_parser.sv
// A byte held in the input register is parsed by the core, which loads its result, if any.
// Throughput: one byte per cycle but for the stall below; the parse state update is one registered step.
// A pending result stalls only a byte that would produce another result.
// Reset clears all parse state, sets nominal_rate and the reported rate to 44100
// and the reported channel count to 2; the block is ready right after reset.
module wav_header_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wavhp_pkg::IN_DATA_W-1:0]     s_tdata,   // byte_value
    input  logic [0:0]                          s_tuser,   // first_of_file
    input  logic                                s_tlast,   // last_of_file
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // payload_offset, data_length, fmt_rate, channel_count, rate_differs, zero pad
    output logic [wavhp_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [wavhp_pkg::OUT_USER_W-1:0]    m_tuser,   // status
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [31:0]                         cfg_data
);
    import wavhp_pkg::*;

    in_item_t    s_item;
    in_item_t    item;
    logic        item_valid;
    logic        out_free;
    core_ctl_t   ctl;
    result_t     core_result;
    result_t     out_result;
    logic [31:0] nominal_rate_reg;

    assign s_item.byte_value    = s_tdata;
    assign s_item.first_of_file = s_tuser[0];
    assign s_item.last_of_file  = s_tlast;

    // Nominal rate register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_rate_reg <= DEFAULT_RATE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            nominal_rate_reg <= cfg_data;
        end
    end

    wavhp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (ctl.step)
    );

    wavhp_parse_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .out_free     (out_free),
        .nominal_rate (nominal_rate_reg),
        .ctl          (ctl),
        .result       (core_result)
    );

    wavhp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (ctl.load),
        .result_in  (core_result),
        .out_free   (out_free),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .result_out (out_result)
    );

    // Output packing, lowest field first.
    assign m_tdata = {7'd0, out_result.rate_differs, out_result.channel_count,
                      out_result.fmt_rate, out_result.data_length,
                      out_result.payload_offset};
    assign m_tuser = out_result.status;

`ifndef SYNTH
    // A new result never overwrites one still waiting downstream.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending result");

    // An accepted data chunk lies past the RIFF header and chunk header.
    a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_OK) |-> (m_tdata[31:0] >= 32'd20))
        else $error("ok result with impossible data offset");

    // A bad tag is found before any data chunk, so no offset or length.
    a_bad_tag_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_BAD_TAG) |-> (m_tdata[63:0] == 64'd0))
        else $error("bad tag result carries data chunk fields");

    // A byte leaves the input stage only when it was held there.
    a_step_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |-> item_valid)
        else $error("parse step without a held byte");
`endif

endmodule
